// File: design/sap_pkg.sv
package sap_pkg;

    // Fixed point format and pipeline sizing
    localparam int SAP_FRAC_BITS  = 16;
    localparam int SAP_SUM_W      = 65;   // dx^2 + dy^2
    localparam int SAP_DIST_W     = 33;   // floor(sqrt(sum))
    localparam int SAP_NUM_W      = 64;
    localparam int SAP_Q1_W       = 33;   // speed scale / prediction quotient
    localparam int SAP_Q2_W       = 31;   // velocity quotient
    localparam int SAP_LATENCY    = 3 + SAP_DIST_W + 1 + SAP_Q1_W + 3 + SAP_Q2_W + 2;

    typedef enum logic
    {
        FUNC_ARRIVE  = 1'b0,
        FUNC_PURSUIT = 1'b1
    } func_t;

    typedef struct packed
    {
        logic               func;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic [30:0]        speed;
        logic [30:0]        target_speed;
        logic [30:0]        arrive_radius;
        logic [30:0]        max_prediction;
        logic [30:0]        step_time;
    } cmd_t;

    typedef struct packed
    {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } res_t;

    // Per-agent context carried beside the arithmetic units
    typedef struct packed
    {
        logic               func;
        logic               sgn_x;
        logic               sgn_y;
        logic [31:0]        adx;
        logic [31:0]        ady;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic [30:0]        speed;
        logic [30:0]        target_speed;
        logic [30:0]        arrive_radius;
        logic [30:0]        max_prediction;
        logic [30:0]        step_time;
    } ctx_t;

    // Context kept through the velocity divider
    typedef struct packed
    {
        logic               zero;
        logic               sgn_x;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic [30:0]        step_time;
    } fin_t;

endpackage

// File: design/sap_isqrt.sv
module sap_isqrt #(
    parameter int IW = sap_pkg::SAP_SUM_W,
    parameter int RW = sap_pkg::SAP_DIST_W,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [IW-1:0] in_val,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [RW-1:0] out_root,
    output logic [SW-1:0] out_side
);
    import sap_pkg::*;

    localparam int TW = 2 * RW + 2;

    logic [RW-1:0] vld_reg;
    logic [IW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            localparam int I = RW - 1 - k;
            logic          vld_in;
            logic [IW-1:0] rem_in;
            logic [RW-1:0] root_in;
            logic [SW-1:0] side_in;
            logic [TW-1:0] trial;
            logic          ge;
            logic [IW-1:0] rem_next;
            logic [RW-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rem_in  = in_val;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // Try setting this root bit: (r + 2^I)^2 - r^2 = r*2^(I+1) + 2^(2I)
            always_comb
            begin
                trial     = (TW'(root_in) << (I + 1)) | (TW'(1) << (2 * I));
                ge        = TW'(rem_in) >= trial;
                rem_next  = ge ? IW'(TW'(rem_in) - trial) : rem_in;
                root_next = ge ? (root_in | (RW'(1) << I)) : root_in;
            end

            // Advance valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            // Advance data
            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_side = side_reg[RW-1];

endmodule

// File: design/sap_div.sv
module sap_div #(
    parameter int NW = sap_pkg::SAP_NUM_W,
    parameter int DW = 31,
    parameter int QW = sap_pkg::SAP_Q1_W,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);
    import sap_pkg::*;

    localparam int TW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [QW-1:0] vld_reg;
    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [SW-1:0] side_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            localparam int I = QW - 1 - k;
            logic          vld_in;
            logic [NW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [SW-1:0] side_in;
            logic [TW-1:0] shifted;
            logic          ge;
            logic [NW-1:0] rem_next;
            logic [QW-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rem_in  = in_num;
                assign den_in  = in_den;
                assign quo_in  = '0;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign quo_in  = quo_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // Subtract the shifted divisor when it fits
            always_comb
            begin
                shifted  = TW'(den_in) << I;
                ge       = TW'(rem_in) >= shifted;
                rem_next = ge ? NW'(TW'(rem_in) - shifted) : rem_in;
                quo_next = ge ? (quo_in | (QW'(1) << I)) : quo_in;
            end

            // Advance valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            // Advance data
            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QW-1];
    assign out_quo  = quo_reg[QW-1];
    assign out_side = side_reg[QW-1];

endmodule

// File: design/steering_arrive_pursuit_unit.sv
// Steering unit: one agent update (arrive or pursuit) per transaction, in signed
// fixed point with FRAC_BITS fraction bits. busy is always low, so a new
// transaction may start in every clock cycle. Each transaction yields one
// result, shown on result for a single cycle with done high. The receiver
// must take it then; nothing is buffered. The pipeline is made of the
// bit-per-stage square root (33 stages), the speed/prediction divider (33
// stages) and the velocity dividers (31 stages), plus nine stages of multiply
// and glue logic.
module steering_arrive_pursuit_unit #(
    parameter int FRAC_BITS = sap_pkg::SAP_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sap_pkg::cmd_t cmd,
    output logic          done,
    output sap_pkg::res_t result
);
    import sap_pkg::*;

    localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
    localparam longint unsigned EPS_RAW = (ONE_L + 64'd5000) / 64'd10000;
    localparam longint unsigned EPS_L   = (EPS_RAW == 64'd0) ? 64'd1 : EPS_RAW;
    localparam logic [63:0]     EPS     = 64'(EPS_L);
    localparam logic [30:0]     ONE     = 31'(ONE_L);

    localparam int CTX_W = $bits(ctx_t);
    localparam int FIN_W = $bits(fin_t);

    // Stage a: differences and magnitudes
    logic        accept;
    logic [32:0] dx_w;
    logic [32:0] dy_w;
    logic [32:0] ndx_w;
    logic [32:0] ndy_w;
    ctx_t        a_ctx_next;
    logic        a_vld_reg;
    ctx_t        a_ctx_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        dx_w  = {cmd.target_x[31], cmd.target_x} - {cmd.self_x[31], cmd.self_x};
        dy_w  = {cmd.target_y[31], cmd.target_y} - {cmd.self_y[31], cmd.self_y};
        ndx_w = 33'd0 - dx_w;
        ndy_w = 33'd0 - dy_w;
        a_ctx_next.func           = cmd.func;
        a_ctx_next.sgn_x          = dx_w[32];
        a_ctx_next.sgn_y          = dy_w[32];
        a_ctx_next.adx            = dx_w[32] ? ndx_w[31:0] : dx_w[31:0];
        a_ctx_next.ady            = dy_w[32] ? ndy_w[31:0] : dy_w[31:0];
        a_ctx_next.self_x         = cmd.self_x;
        a_ctx_next.self_y         = cmd.self_y;
        a_ctx_next.speed          = cmd.speed;
        a_ctx_next.target_speed   = cmd.target_speed;
        a_ctx_next.arrive_radius  = cmd.arrive_radius;
        a_ctx_next.max_prediction = cmd.max_prediction;
        a_ctx_next.step_time      = cmd.step_time;
    end

    // Stage b: squares
    logic        b_vld_reg;
    ctx_t        b_ctx_reg;
    logic [63:0] b_sqx_reg;
    logic [63:0] b_sqy_reg;

    // Stage c: sum of squares
    logic        c_vld_reg;
    ctx_t        c_ctx_reg;
    logic [64:0] c_sum_reg;

    // Square root
    logic                  sq_vld;
    logic [SAP_DIST_W-1:0] sq_root;
    logic [CTX_W-1:0]      sq_side;
    ctx_t                  sq_ctx;

    // Stage d: divider operands
    logic                  d_vld_reg;
    logic [SAP_NUM_W-1:0]  d_num_reg;
    logic [30:0]           d_den_reg;
    ctx_t                  d_ctx_reg;
    logic [SAP_DIST_W-1:0] d_dist_reg;
    logic [SAP_NUM_W-1:0]  d_num_next;
    logic [30:0]           d_den_next;

    // Speed / prediction divider
    logic                        q1_vld;
    logic [SAP_Q1_W-1:0]         q1_quo;
    logic [CTX_W+SAP_DIST_W-1:0] q1_side;
    ctx_t                        q1_ctx;
    logic [SAP_DIST_W-1:0]       q1_dist;

    // Stage e: speed and prediction time
    logic                  e_vld_reg;
    ctx_t                  e_ctx_reg;
    logic [SAP_DIST_W-1:0] e_dist_reg;
    logic [30:0]           e_s_reg;
    logic [30:0]           e_pred_reg;
    logic [30:0]           e_s_next;
    logic [30:0]           e_pred_next;

    // Stage f: products
    logic                  f_vld_reg;
    ctx_t                  f_ctx_reg;
    logic [SAP_DIST_W-1:0] f_dist_reg;
    logic [61:0]           f_m_reg;
    logic [62:0]           f_px_reg;
    logic [62:0]           f_py_reg;

    // Stage g: zero check and velocity divider operands
    logic                  g_vld_reg;
    logic [SAP_NUM_W-1:0]  g_numx_reg;
    logic [SAP_NUM_W-1:0]  g_numy_reg;
    logic [SAP_DIST_W-1:0] g_den_reg;
    fin_t                  g_fin_reg;
    logic                  g_sgny_reg;
    logic [63:0]           g_len_w;
    fin_t                  g_fin_next;

    // Velocity dividers
    logic                q2x_vld;
    logic [SAP_Q2_W-1:0] q2x_quo;
    logic [FIN_W-1:0]    q2x_side;
    logic                q2y_vld;
    logic [SAP_Q2_W-1:0] q2y_quo;
    logic                q2y_side;
    fin_t                q2_fin;

    // Stage h: velocity and displacement products
    logic                h_vld_reg;
    logic signed [31:0]  h_velx_reg;
    logic signed [31:0]  h_vely_reg;
    logic [61:0]         h_mx_reg;
    logic [61:0]         h_my_reg;
    logic                h_sgnx_reg;
    logic                h_sgny_reg;
    logic signed [31:0]  h_selfx_reg;
    logic signed [31:0]  h_selfy_reg;
    logic [30:0]         h_qx_w;
    logic [30:0]         h_qy_w;

    // Stage i: result
    logic i_vld_reg;
    res_t i_res_reg;

    function automatic logic signed [31:0] advance(input logic signed [31:0] p,
                                                   input logic neg,
                                                   input logic [61:0] prod);
        logic signed [63:0] m;
        logic signed [63:0] sum;
        m   = 64'(prod >> FRAC_BITS);
        sum = neg ? (64'(p) - m) : (64'(p) + m);
        if (sum > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (sum < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    // Hold valid bits of the glue stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= sq_vld;
            e_vld_reg <= q1_vld;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= q2x_vld && q2y_vld;
            i_vld_reg <= h_vld_reg;
        end
    end

    // Front stages: magnitudes, squares, sum
    always_ff @(posedge clk)
    begin
        a_ctx_reg <= a_ctx_next;
        b_ctx_reg <= a_ctx_reg;
        b_sqx_reg <= 64'(a_ctx_reg.adx) * 64'(a_ctx_reg.adx);
        b_sqy_reg <= 64'(a_ctx_reg.ady) * 64'(a_ctx_reg.ady);
        c_ctx_reg <= b_ctx_reg;
        c_sum_reg <= 65'(b_sqx_reg) + 65'(b_sqy_reg);
    end

    sap_isqrt #(
        .IW (SAP_SUM_W),
        .RW (SAP_DIST_W),
        .SW (CTX_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (c_vld_reg),
        .in_val   (c_sum_reg),
        .in_side  (c_ctx_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // Select divider operands by mode
    always_comb
    begin
        sq_ctx = ctx_t'(sq_side);
        if (sq_ctx.func == FUNC_PURSUIT)
        begin
            d_num_next = 64'(sq_root) << FRAC_BITS;
            d_den_next = (sq_ctx.target_speed < ONE) ? ONE : sq_ctx.target_speed;
        end
        else
        begin
            d_num_next = 64'(sq_ctx.speed) * 64'(sq_root);
            d_den_next = sq_ctx.arrive_radius;
        end
    end

    always_ff @(posedge clk)
    begin
        d_num_reg  <= d_num_next;
        d_den_reg  <= d_den_next;
        d_ctx_reg  <= sq_ctx;
        d_dist_reg <= sq_root;
    end

    sap_div #(
        .NW (SAP_NUM_W),
        .DW (31),
        .QW (SAP_Q1_W),
        .SW (CTX_W + SAP_DIST_W)
    ) u_div_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (d_vld_reg),
        .in_num   (d_num_reg),
        .in_den   (d_den_reg),
        .in_side  ({d_ctx_reg, d_dist_reg}),
        .out_vld  (q1_vld),
        .out_quo  (q1_quo),
        .out_side (q1_side)
    );

    // Pick the speed and clamp the prediction time
    always_comb
    begin
        q1_ctx  = ctx_t'(q1_side[CTX_W+SAP_DIST_W-1:SAP_DIST_W]);
        q1_dist = q1_side[SAP_DIST_W-1:0];
        if (q1_ctx.func == FUNC_ARRIVE && q1_dist < SAP_DIST_W'(q1_ctx.arrive_radius))
        begin
            e_s_next = q1_quo[30:0];
        end
        else
        begin
            e_s_next = q1_ctx.speed;
        end
        e_pred_next = (q1_quo > SAP_Q1_W'(q1_ctx.max_prediction)) ?
                      q1_ctx.max_prediction : q1_quo[30:0];
    end

    always_ff @(posedge clk)
    begin
        e_ctx_reg  <= q1_ctx;
        e_dist_reg <= q1_dist;
        e_s_reg    <= e_s_next;
        e_pred_reg <= e_pred_next;
        f_ctx_reg  <= e_ctx_reg;
        f_dist_reg <= e_dist_reg;
        f_m_reg    <= 62'(e_ctx_reg.target_speed) * 62'(e_pred_reg);
        f_px_reg   <= 63'(e_ctx_reg.adx) * 63'(e_s_reg);
        f_py_reg   <= 63'(e_ctx_reg.ady) * 63'(e_s_reg);
    end

    // Drop the velocity near the target or the aim point
    always_comb
    begin
        g_len_w = 64'(f_dist_reg) + 64'(f_m_reg >> FRAC_BITS);
        if (f_ctx_reg.func == FUNC_PURSUIT)
        begin
            g_fin_next.zero = (f_dist_reg == '0) || (g_len_w < EPS);
        end
        else
        begin
            g_fin_next.zero = 64'(f_dist_reg) < EPS;
        end
        g_fin_next.sgn_x     = f_ctx_reg.sgn_x;
        g_fin_next.self_x    = f_ctx_reg.self_x;
        g_fin_next.self_y    = f_ctx_reg.self_y;
        g_fin_next.step_time = f_ctx_reg.step_time;
    end

    always_ff @(posedge clk)
    begin
        g_numx_reg <= 64'(f_px_reg);
        g_numy_reg <= 64'(f_py_reg);
        g_den_reg  <= f_dist_reg;
        g_fin_reg  <= g_fin_next;
        g_sgny_reg <= f_ctx_reg.sgn_y;
    end

    sap_div #(
        .NW (SAP_NUM_W),
        .DW (SAP_DIST_W),
        .QW (SAP_Q2_W),
        .SW (FIN_W)
    ) u_div_vx (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (g_vld_reg),
        .in_num   (g_numx_reg),
        .in_den   (g_den_reg),
        .in_side  (g_fin_reg),
        .out_vld  (q2x_vld),
        .out_quo  (q2x_quo),
        .out_side (q2x_side)
    );

    sap_div #(
        .NW (SAP_NUM_W),
        .DW (SAP_DIST_W),
        .QW (SAP_Q2_W),
        .SW (1)
    ) u_div_vy (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (g_vld_reg),
        .in_num   (g_numy_reg),
        .in_den   (g_den_reg),
        .in_side  (g_sgny_reg),
        .out_vld  (q2y_vld),
        .out_quo  (q2y_quo),
        .out_side (q2y_side)
    );

    // Apply sign and zero rule
    always_comb
    begin
        q2_fin = fin_t'(q2x_side);
        h_qx_w = q2_fin.zero ? 31'd0 : q2x_quo;
        h_qy_w = q2_fin.zero ? 31'd0 : q2y_quo;
    end

    always_ff @(posedge clk)
    begin
        h_velx_reg  <= q2_fin.sgn_x ? (32'sd0 - 32'(h_qx_w)) : 32'(h_qx_w);
        h_vely_reg  <= q2y_side ? (32'sd0 - 32'(h_qy_w)) : 32'(h_qy_w);
        h_mx_reg    <= 62'(h_qx_w) * 62'(q2_fin.step_time);
        h_my_reg    <= 62'(h_qy_w) * 62'(q2_fin.step_time);
        h_sgnx_reg  <= q2_fin.sgn_x;
        h_sgny_reg  <= q2y_side;
        h_selfx_reg <= q2_fin.self_x;
        h_selfy_reg <= q2_fin.self_y;
    end

    // Advance position and saturate
    always_ff @(posedge clk)
    begin
        i_res_reg.vel_x <= h_velx_reg;
        i_res_reg.vel_y <= h_vely_reg;
        i_res_reg.new_x <= advance(h_selfx_reg, h_sgnx_reg, h_mx_reg);
        i_res_reg.new_y <= advance(h_selfy_reg, h_sgny_reg, h_my_reg);
    end

    assign done   = i_vld_reg;
    assign result = i_res_reg;

endmodule

// File: design/sap_checker.sv
module sap_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input sap_pkg::cmd_t cmd,
    input logic          done,
    input sap_pkg::res_t result
);
    import sap_pkg::*;

    // Never hold off a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Each accepted transaction is followed by a result with done high
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##SAP_LATENCY done)
        else $error("result missing");

    // No result without a transaction
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, SAP_LATENCY))
        else $error("spurious result");

    // Zero velocity keeps the position
    a_zero_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.vel_x == 32'sd0 && result.vel_y == 32'sd0) |->
        (result.new_x == $past(cmd.self_x, SAP_LATENCY) &&
         result.new_y == $past(cmd.self_y, SAP_LATENCY)))
        else $error("position moved at zero velocity");

    // Arriving on the target point gives zero velocity
    a_on_target: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.func == FUNC_ARRIVE && cmd.target_x == cmd.self_x &&
                       cmd.target_y == cmd.self_y, SAP_LATENCY)) |->
        (result.vel_x == 32'sd0 && result.vel_y == 32'sd0))
        else $error("nonzero velocity on target");

endmodule

bind steering_arrive_pursuit_unit sap_checker u_sap_checker (.*);
